// ----- sv/plfk_pkg.sv -----
package plfk_pkg;

  localparam int CordicSteps = 16;
  localparam int AngW = 20;   // Q16 angle, holds +-4.0 * 2^16 plus margin
  localparam int CsW = 19;    // sin/cos Q16 with CORDIC gain margin
  localparam int LenW = 14;
  localparam int PosW = 16;
  localparam int AccW = 20;   // unsaturated position accumulator
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegThigh = 2'd0;
  localparam logic [CfgIdxW-1:0] RegShin  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFoot  = 2'd2;

  localparam logic signed [AngW-1:0] Q16Pi     = 20'sd205887;
  localparam logic signed [AngW-1:0] Q16HalfPi = 20'sd102944;
  localparam logic signed [CsW-1:0]  CordicStart = 19'sd39797;

  localparam logic [LenW-1:0] ThighReset = 14'd4480;
  localparam logic [LenW-1:0] ShinReset  = 14'd4480;
  localparam logic [LenW-1:0] FootReset  = 14'd960;

  localparam int QueueDepth = 4;

  typedef struct packed {
    logic signed [PosW-1:0] hip_x;
    logic signed [PosW-1:0] hip_y;
    logic signed [PosW-1:0] hip_angle;
    logic signed [PosW-1:0] knee_angle;
    logic signed [PosW-1:0] ankle_angle;
  } pose_t;

  typedef struct packed {
    logic signed [PosW-1:0] knee_x;
    logic signed [PosW-1:0] knee_y;
    logic signed [PosW-1:0] ankle_x;
    logic signed [PosW-1:0] ankle_y;
    logic signed [PosW-1:0] foot_x;
    logic signed [PosW-1:0] foot_y;
  } legpos_t;

  function automatic logic signed [AngW-1:0] atan_q16(input int i);
    case (i)
      0: atan_q16 = 20'sd51472;
      1: atan_q16 = 20'sd30386;
      2: atan_q16 = 20'sd16055;
      3: atan_q16 = 20'sd8150;
      4: atan_q16 = 20'sd4091;
      5: atan_q16 = 20'sd2047;
      6: atan_q16 = 20'sd1024;
      7: atan_q16 = 20'sd512;
      8: atan_q16 = 20'sd256;
      9: atan_q16 = 20'sd128;
      10: atan_q16 = 20'sd64;
      11: atan_q16 = 20'sd32;
      12: atan_q16 = 20'sd16;
      13: atan_q16 = 20'sd8;
      14: atan_q16 = 20'sd4;
      default: atan_q16 = 20'sd2;
    endcase
  endfunction

  function automatic logic signed [PosW-1:0] sat16(input logic signed [AccW-1:0] v);
    if (v > $signed({{(AccW-PosW){1'b0}}, 16'h7fff})) sat16 = 16'sh7fff;
    else if (v < $signed({{(AccW-PosW){1'b1}}, 16'h8000})) sat16 = 16'sh8000;
    else sat16 = v[PosW-1:0];
  endfunction

endpackage

// ----- sv/plfk_queue.sv -----
// Small FIFO between the input front and the kinematics back end.
module plfk_queue #(
  parameter int Width = 80,
  parameter int Depth = plfk_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [Width-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [Width-1:0] rd_data
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [PtrW:0] count;
  logic do_wr, do_rd;

  assign wr_ready = (count != Depth[PtrW:0]);
  assign rd_valid = (count != '0);
  assign rd_data = mem[rd_ptr];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  // store incoming word
  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + {{PtrW{1'b0}}, do_wr} - {{PtrW{1'b0}}, do_rd};
    end
  end
endmodule

// ----- sv/plfk_front.sv -----
// Input front: take words, widen angles to Q16 and fold into [-pi/2, pi/2].
module plfk_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  plfk_pkg::pose_t       in_pose,
  output logic                  q_valid,
  input  logic                  q_ready,
  output logic [3*plfk_pkg::AngW+2*plfk_pkg::PosW+2:0] q_data
);
  localparam int AngW = plfk_pkg::AngW;

  logic signed [AngW-1:0] z [3];
  logic flip [3];
  logic signed [plfk_pkg::PosW-1:0] ang [3];
  logic valid;
  logic [3*AngW+2*plfk_pkg::PosW+2:0] data;

  assign ang[0] = in_pose.hip_angle;
  assign ang[1] = in_pose.knee_angle;
  assign ang[2] = in_pose.ankle_angle;

  // classify each angle for the quadrant fold
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [AngW-1:0] w;
      w = {{(AngW-plfk_pkg::PosW-3){ang[i][plfk_pkg::PosW-1]}}, ang[i], 3'b000};
      flip[i] = 1'b0;
      z[i] = w;
      if (w > plfk_pkg::Q16HalfPi) begin
        z[i] = w - plfk_pkg::Q16Pi;
        flip[i] = 1'b1;
      end else if (w < -plfk_pkg::Q16HalfPi) begin
        z[i] = w + plfk_pkg::Q16Pi;
        flip[i] = 1'b1;
      end
    end
  end

  assign in_ready = !valid || q_ready;
  assign q_valid = valid;
  assign q_data = data;

  // hold one classified word for the queue
  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (in_ready) valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid)
      data <= {flip[2], flip[1], flip[0], z[2], z[1], z[0], in_pose.hip_y, in_pose.hip_x};
  end
endmodule

// ----- sv/plfk_back.sv -----
// Back end: pipelined CORDIC for all three angles, then chained rotations.
module plfk_back (
  input  logic clk,
  input  logic rst,
  input  logic [plfk_pkg::LenW-1:0] thigh_length,
  input  logic [plfk_pkg::LenW-1:0] shin_length,
  input  logic [plfk_pkg::LenW-1:0] foot_length,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic [3*plfk_pkg::AngW+2*plfk_pkg::PosW+2:0] q_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output plfk_pkg::legpos_t     out_pos
);
  localparam int N = plfk_pkg::CordicSteps;
  localparam int AngW = plfk_pkg::AngW;
  localparam int CsW = plfk_pkg::CsW;
  localparam int PosW = plfk_pkg::PosW;
  localparam int AccW = plfk_pkg::AccW;
  localparam int LenW = plfk_pkg::LenW;
  localparam int PW = 2 * CsW + 1;   // sum of two Q32 products

  // the whole pipe advances together; skid is the output register
  logic adv;
  assign adv = !out_valid || out_ready;
  assign q_ready = adv;

  // CORDIC stages
  logic signed [CsW-1:0] cx [N+1][3];
  logic signed [CsW-1:0] cy [N+1][3];
  logic signed [AngW-1:0] cz [N+1][3];
  logic flp [N+1][3];
  logic signed [PosW-1:0] hx [N+1];
  logic signed [PosW-1:0] hy [N+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        cx[0][k] <= plfk_pkg::CordicStart;
        cy[0][k] <= '0;
        cz[0][k] <= q_data[2*PosW + k*AngW +: AngW];
        flp[0][k] <= q_data[2*PosW + 3*AngW + k];
      end
      hx[0] <= q_data[PosW-1:0];
      hy[0] <= q_data[2*PosW-1:PosW];
      for (int i = 0; i < N; i++) begin
        for (int k = 0; k < 3; k++) begin
          if (!cz[i][k][AngW-1]) begin
            cx[i+1][k] <= cx[i][k] - (cy[i][k] >>> i);
            cy[i+1][k] <= cy[i][k] + (cx[i][k] >>> i);
            cz[i+1][k] <= cz[i][k] - plfk_pkg::atan_q16(i);
          end else begin
            cx[i+1][k] <= cx[i][k] + (cy[i][k] >>> i);
            cy[i+1][k] <= cy[i][k] - (cx[i][k] >>> i);
            cz[i+1][k] <= cz[i][k] + plfk_pkg::atan_q16(i);
          end
          flp[i+1][k] <= flp[i][k];
        end
        hx[i+1] <= hx[i];
        hy[i+1] <= hy[i];
      end
    end
  end

  // apply fold sign: s = y, c = x
  logic signed [CsW-1:0] sn [3], cs [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sn[k] = flp[N][k] ? -cy[N][k] : cy[N][k];
      cs[k] = flp[N][k] ? -cx[N][k] : cx[N][k];
    end
  end

  function automatic logic signed [CsW-1:0] rnd_cs(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + PW'(32768)) >>> 16;
    rnd_cs = t[CsW-1:0];
  endfunction

  function automatic logic signed [AccW-1:0] rnd_off(input logic signed [LenW+CsW:0] p);
    logic signed [LenW+CsW:0] t;
    t = (p + (LenW+CsW+1)'(32768)) >>> 16;
    rnd_off = t[AccW-1:0];
  endfunction

  // stage A: knee products, knee-rotation products
  logic signed [LenW+CsW:0] pk_x, pk_y;
  logic signed [2*CsW-1:0] a1, a2, a3, a4;
  logic signed [CsW-1:0] sa2, ca2;
  logic signed [AccW-1:0] hxa, hya;
  always_ff @(posedge clk) begin
    if (adv) begin
      pk_x <= $signed({1'b0, thigh_length}) * sn[0];
      pk_y <= $signed({1'b0, thigh_length}) * cs[0];
      // d = -(s0, c0); u = (c*dx + s*dy, -s*dx + c*dy)
      a1 <= cs[1] * (-sn[0]);
      a2 <= sn[1] * (-cs[0]);
      a3 <= sn[1] * sn[0];
      a4 <= cs[1] * (-cs[0]);
      sa2 <= sn[2];
      ca2 <= cs[2];
      hxa <= AccW'(hx[N]);
      hya <= AccW'(hy[N]);
    end
  end

  // stage B: knee position, first direction
  logic signed [AccW-1:0] kx_b, ky_b;
  logic signed [CsW-1:0] u1x, u1y, sb2, cb2;
  always_ff @(posedge clk) begin
    if (adv) begin
      kx_b <= hxa + rnd_off(pk_x);
      ky_b <= hya + rnd_off(pk_y);
      u1x <= rnd_cs(PW'(a1) + PW'(a2));
      u1y <= rnd_cs(PW'(a3) + PW'(a4));
      sb2 <= sa2;
      cb2 <= ca2;
    end
  end

  // stage C: shin products, ankle-rotation products
  logic signed [LenW+CsW:0] ps_x, ps_y;
  logic signed [2*CsW-1:0] b1, b2, b3, b4;
  logic signed [AccW-1:0] kx_c, ky_c;
  always_ff @(posedge clk) begin
    if (adv) begin
      ps_x <= $signed({1'b0, shin_length}) * u1x;
      ps_y <= $signed({1'b0, shin_length}) * u1y;
      b1 <= cb2 * (-u1x);
      b2 <= sb2 * (-u1y);
      b3 <= sb2 * u1x;
      b4 <= cb2 * (-u1y);
      kx_c <= kx_b;
      ky_c <= ky_b;
    end
  end

  // stage D: ankle position, second direction
  logic signed [AccW-1:0] kx_d, ky_d, ax_d, ay_d;
  logic signed [CsW-1:0] u2x, u2y;
  always_ff @(posedge clk) begin
    if (adv) begin
      ax_d <= kx_c + rnd_off(ps_x);
      ay_d <= ky_c + rnd_off(ps_y);
      u2x <= rnd_cs(PW'(b1) + PW'(b2));
      u2y <= rnd_cs(PW'(b3) + PW'(b4));
      kx_d <= kx_c;
      ky_d <= ky_c;
    end
  end

  // stage E: foot products
  logic signed [LenW+CsW:0] pf_x, pf_y;
  logic signed [AccW-1:0] kx_e, ky_e, ax_e, ay_e;
  always_ff @(posedge clk) begin
    if (adv) begin
      pf_x <= $signed({1'b0, foot_length}) * u2x;
      pf_y <= $signed({1'b0, foot_length}) * u2y;
      kx_e <= kx_d;
      ky_e <= ky_d;
      ax_e <= ax_d;
      ay_e <= ay_d;
    end
  end

  // stage F: foot position and saturation into the output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_pos.knee_x <= plfk_pkg::sat16(kx_e);
      out_pos.knee_y <= plfk_pkg::sat16(ky_e);
      out_pos.ankle_x <= plfk_pkg::sat16(ax_e);
      out_pos.ankle_y <= plfk_pkg::sat16(ay_e);
      out_pos.foot_x <= plfk_pkg::sat16(ax_e + rnd_off(pf_x));
      out_pos.foot_y <= plfk_pkg::sat16(ay_e + rnd_off(pf_y));
    end
  end

  // valid line alongside the data path: input stage, N CORDIC stages, stages A to F
  localparam int VL = N + 7;
  logic [VL-1:0] vl;
  always_ff @(posedge clk) begin
    if (rst) vl <= '0;
    else if (adv) vl <= {vl[VL-2:0], q_valid};
  end
  assign out_valid = vl[VL-1];
endmodule

// ----- sv/planar_leg_forward_kinematics_core.sv -----
// Path: front register, queue, then the back pipe (input stage, CORDIC stages, A to F).
// Throughput: one pose per cycle unstalled; 16-stage CORDIC runs all three angles at once.
// A four-entry queue decouples the front from the back; backpressure stalls the back pipe.
// Reset (rst, synchronous, high) empties the queue and pipe and restores the lengths
// to thigh 4480, shin 4480, foot 960.
module planar_leg_forward_kinematics_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // hip_x, hip_y, hip_angle, knee_angle, ankle_angle (lowest first)
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // knee_x, knee_y, ankle_x, ankle_y, foot_x, foot_y (lowest first)
  output logic [95:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [plfk_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [plfk_pkg::LenW-1:0]    cfg_data
);
  localparam int QW = 3*plfk_pkg::AngW + 2*plfk_pkg::PosW + 3;

  logic [plfk_pkg::LenW-1:0] thigh_length, shin_length, foot_length;

  // length registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thigh_length <= plfk_pkg::ThighReset;
      shin_length <= plfk_pkg::ShinReset;
      foot_length <= plfk_pkg::FootReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        plfk_pkg::RegThigh: thigh_length <= cfg_data;
        plfk_pkg::RegShin: shin_length <= cfg_data;
        plfk_pkg::RegFoot: foot_length <= cfg_data;
        default: ;
      endcase
    end
  end

  plfk_pkg::pose_t pose;
  assign pose.hip_x = s_axis_tdata[15:0];
  assign pose.hip_y = s_axis_tdata[31:16];
  assign pose.hip_angle = s_axis_tdata[47:32];
  assign pose.knee_angle = s_axis_tdata[63:48];
  assign pose.ankle_angle = s_axis_tdata[79:64];

  logic f_valid, f_ready, b_valid, b_ready;
  logic [QW-1:0] f_data, b_data;
  plfk_pkg::legpos_t res;

  plfk_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_pose(pose),
    .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
  );

  plfk_queue #(.Width(QW), .Depth(plfk_pkg::QueueDepth)) u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  plfk_back u_back (
    .clk(clk), .rst(rst),
    .thigh_length(thigh_length), .shin_length(shin_length), .foot_length(foot_length),
    .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_pos(res)
  );

  assign m_axis_tdata = {res.foot_y, res.foot_x, res.ankle_y, res.ankle_x,
                         res.knee_y, res.knee_x};
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam logic [plfk_pkg::CfgIdxW-1:0] RegUnused = 2'd3;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 40;

  // Own model of the leg: CORDIC sin/cos, rotate unit directions, accumulate, clip
  class leg_scoreboard;
    logic [plfk_pkg::LenW-1:0] thigh_len, shin_len, foot_len;
    logic [95:0] pending_legs[$];
    longint atan_tbl[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};
    int mismatches;
    int stray_results;
    int legs_checked;

    function new();
      thigh_len = plfk_pkg::ThighReset;
      shin_len = plfk_pkg::ShinReset;
      foot_len = plfk_pkg::FootReset;
    endfunction

    function void set_length(logic [plfk_pkg::CfgIdxW-1:0] idx,
                             logic [plfk_pkg::LenW-1:0] v);
      case (idx)
        plfk_pkg::RegThigh: thigh_len = v;
        plfk_pkg::RegShin: shin_len = v;
        plfk_pkg::RegFoot: foot_len = v;
        default: ;
      endcase
    endfunction

    function longint rnd(longint v);
      return (v + 32768) >>> 16;
    endfunction

    function logic [plfk_pkg::PosW-1:0] clip(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[plfk_pkg::PosW-1:0];
    endfunction

    // angle is Q3.13; sine and cosine come back Q16
    function void sin_cos(input longint ang, output longint s, output longint c);
      longint z, x, y, xs, ys;
      bit flip;
      z = ang * 8;
      x = 39797;
      y = 0;
      flip = 0;
      if (z > 102944) begin
        z -= 205887;
        flip = 1;
      end else if (z < -102944) begin
        z += 205887;
        flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z -= atan_tbl[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z += atan_tbl[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void note_pose(logic [79:0] d);
      longint hx, hy, s, c, dx, dy, ux, uy, kx, ky, ax, ay, fx, fy;
      hx = longint'($signed(d[15:0]));
      hy = longint'($signed(d[31:16]));
      sin_cos(longint'($signed(d[47:32])), s, c);
      kx = hx + rnd(longint'(thigh_len) * s);
      ky = hy + rnd(longint'(thigh_len) * c);
      // ankle: turn the knee-to-hip direction by the knee angle
      dx = -s;
      dy = -c;
      sin_cos(longint'($signed(d[63:48])), s, c);
      ux = rnd(c * dx + s * dy);
      uy = rnd(-s * dx + c * dy);
      ax = kx + rnd(longint'(shin_len) * ux);
      ay = ky + rnd(longint'(shin_len) * uy);
      // foot: turn the ankle-to-knee direction by the ankle angle
      dx = -ux;
      dy = -uy;
      sin_cos(longint'($signed(d[79:64])), s, c);
      ux = rnd(c * dx + s * dy);
      uy = rnd(-s * dx + c * dy);
      fx = ax + rnd(longint'(foot_len) * ux);
      fy = ay + rnd(longint'(foot_len) * uy);
      pending_legs.push_back({clip(fy), clip(fx), clip(ay), clip(ax), clip(ky), clip(kx)});
    endfunction

    function void check_leg(logic [95:0] got);
      logic [95:0] want;
      string names[6] = '{"knee_x", "knee_y", "ankle_x", "ankle_y", "foot_x", "foot_y"};
      bit bad;
      if (pending_legs.size() == 0) begin
        stray_results++;
        if (stray_results + mismatches <= 10)
          $display("unexpected result word %h", got);
        return;
      end
      want = pending_legs.pop_front();
      legs_checked++;
      bad = 0;
      for (int f = 0; f < 6; f++) begin
        if (got[f*16 +: 16] !== want[f*16 +: 16]) begin
          if (!bad) mismatches++;
          bad = 1;
          if (mismatches <= 10)
            $display("mismatch on result %0d, %s: expected %0d, got %0d", legs_checked,
                     names[f], $signed(want[f*16 +: 16]), $signed(got[f*16 +: 16]));
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [95:0] m_axis_tdata;
  logic cfg_we = 0;
  logic [plfk_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [plfk_pkg::LenW-1:0] cfg_data = '0;

  leg_scoreboard legs = new();
  bit idling = 1;
  int cycles = 0;
  int poses_sent = 0;
  int stall_left = 0;

  planar_leg_forward_kinematics_core i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // check result words and, while idling is set, stall the output side in bursts
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) legs.check_leg(m_axis_tdata);
    if (rst) begin
      m_axis_tready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 0;
    end else if (idling && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 12);
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb failed");
      $finish;
    end
  end

  task automatic send_pose(logic [15:0] hx, hy, ha, ka, aa);
    if (idling && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {aa, ka, ha, hy, hx};
    do @(posedge clk); while (!s_axis_tready);
    legs.note_pose({aa, ka, ha, hy, hx});
    poses_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (legs.pending_legs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // one write, then cfg_we low again so the next write starts on a fresh edge
  task automatic write_reg(logic [plfk_pkg::CfgIdxW-1:0] idx, logic [plfk_pkg::LenW-1:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    legs.set_length(idx, v);
    @(posedge clk);
  endtask

  task automatic set_lengths(logic [plfk_pkg::LenW-1:0] t, sh, f);
    write_reg(plfk_pkg::RegThigh, t);
    write_reg(plfk_pkg::RegShin, sh);
    write_reg(plfk_pkg::RegFoot, f);
  endtask

  task automatic directed_poses();
    logic [15:0] angs[8] = '{16'h0000, 16'h7fff, 16'h8000, 16'd12868, 16'd12869,
                             -16'sd12868, -16'sd12869, 16'd25736};
    send_pose(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_pose(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_pose(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pose(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    foreach (angs[i]) send_pose(16'h7f00, 16'h8100, angs[i], angs[7 - i], angs[(i + 3) % 8]);
    send_pose(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
    send_pose(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
  endtask

  task automatic random_poses(int n);
    logic [15:0] hx, hy;
    for (int k = 0; k < n; k++) begin
      // mostly hips near the origin so the leg stays in range; some anywhere
      if ($urandom_range(0, 3) == 0) begin
        hx = 16'($urandom);
        hy = 16'($urandom);
      end else begin
        hx = 16'($urandom_range(0, 16383) - 8192);
        hy = 16'($urandom_range(0, 16383) - 8192);
      end
      send_pose(hx, hy, 16'($urandom), 16'($urandom), 16'($urandom));
      if (k == n / 2) drain();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset lengths
    directed_poses();
    random_poses(300);
    drain();

    // zero lengths, and a write to the unused index that must change nothing
    set_lengths(14'd0, 14'd0, 14'd0);
    write_reg(RegUnused, 14'h3fff);
    directed_poses();
    random_poses(250);
    drain();

    // longest segments
    set_lengths(14'h3fff, 14'h3fff, 14'h3fff);
    directed_poses();
    random_poses(300);
    drain();

    // random lengths, three settings
    repeat (3) begin
      set_lengths(14'($urandom), 14'($urandom), 14'($urandom));
      random_poses(200);
      drain();
    end

    // back to reset values, no idling on either side
    set_lengths(plfk_pkg::ThighReset, plfk_pkg::ShinReset, plfk_pkg::FootReset);
    idling = 0;
    random_poses(250);
    drain();

    $display("sent %0d poses over seven length settings, checked %0d results",
             poses_sent, legs.legs_checked);
    $display("mismatches %0d, unexpected results %0d, missing %0d", legs.mismatches,
             legs.stray_results, legs.pending_legs.size());
    if (legs.mismatches == 0 && legs.stray_results == 0 && legs.pending_legs.size() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end
endmodule
